// ===== rtl/core/harmonic_salience_accumulator_assert.svh =====
// Assertion helpers used by the salience accumulator RTL.
// Both expect clk and rst_n in scope; checks are off while reset is held.
`ifndef HARMONIC_SALIENCE_ACCUMULATOR_ASSERT_SVH
`define HARMONIC_SALIENCE_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication
`define HSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define HSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hsa_pkg.sv =====
`default_nettype none
package hsa_pkg;

  // map geometry
  localparam int BINS      = 480;
  localparam int HARMONICS = 8;
  localparam int SPREAD    = 10;
  localparam int SPEC_W    = 11;
  localparam int MAG_W     = 16;
  localparam int SAL_W     = 32;
  localparam int OFS_W     = 21;

  localparam int BIN_AW = $clog2(BINS);
  localparam int BIN_W  = 9;
  localparam int HW     = $clog2(HARMONICS);
  localparam int DI_W   = $clog2(2 * SPREAD + 1);
  localparam int K_W    = $clog2(SPREAD + 1);
  localparam int LG_W   = 19;
  localparam int W_W    = 16;

  localparam logic signed [OFS_W-1:0] OFFSET_RST = -21'sd63488;

  // cos^2 taper and per-harmonic decay, Q1.15
  localparam int unsigned COS2 [0:SPREAD] = '{
    32768, 31966, 29639, 26014, 21447, 16384, 11321, 6754, 3129, 802, 0
  };
  localparam int unsigned DEC [0:15] = '{
    32768, 26214, 20972, 16777, 13422, 10737, 8590, 6872,
    5498, 4398, 3518, 2815, 2252, 1801, 1441, 1153
  };

  typedef logic [LG_W-1:0] lg_t;
  typedef lg_t [HARMONICS-1:0] lgh_tab_t;
  typedef logic [W_W-1:0] w_t;
  typedef w_t [SPREAD:0] w_row_t;
  typedef w_row_t [HARMONICS-1:0] w_tab_t;

  // 120*log2(x) in Q.8 by repeated squaring; elaboration use only
  function automatic lg_t lg_const(input int unsigned x);
    int unsigned e;
    int unsigned frac;
    longint unsigned m;
    longint unsigned q;
    e = 0;
    frac = 0;
    while (e < 30 && (x >> e) > 1) e++;
    m = longint'(x) << (30 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    q = (longint'(e) << 16) | longint'(frac);
    return LG_W'((q * 120 + 128) >> 8);
  endfunction

  function automatic lgh_tab_t build_lgh();
    lgh_tab_t t;
    for (int h = 0; h < HARMONICS; h++) t[h] = lg_const(h + 1);
    return t;
  endfunction

  function automatic w_tab_t build_w();
    w_tab_t t;
    for (int h = 0; h < HARMONICS; h++)
      for (int k = 0; k <= SPREAD; k++)
        t[h][k] = W_W'((COS2[k] * DEC[h & 15] + 16384) >> 15);
    return t;
  endfunction

  localparam lgh_tab_t LGH  = build_lgh();
  localparam w_tab_t   WTAB = build_w();

  // controller -> datapath
  typedef struct packed {
    logic              load;
    logic              sq_en;
    logic [1:0]        sq_step;
    logic              log_fin;
    logic              centre;
    logic [HW-1:0]     h;
    logic              issue;
    logic [DI_W-1:0]   di;
    logic              rd_issue;
    logic              rd_done;
    logic              clr;
    logic [BIN_AW-1:0] clr_addr;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_read;
    logic req_skip;
  } status_t;

  localparam logic [1:0] SQ_LO  = 2'd0;
  localparam logic [1:0] SQ_MID = 2'd1;
  localparam logic [1:0] SQ_HI  = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/core/hsa_ctrl.sv =====
`default_nettype none
module hsa_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  hsa_pkg::status_t status,
  output hsa_pkg::cmd_t   cmd,
  output logic            busy,
  output logic            out_strobe
);
  import hsa_pkg::*;

  typedef enum logic [9:0] {
    ST_CLEAR    = 10'b00_0000_0001,
    ST_IDLE     = 10'b00_0000_0010,
    ST_LOG      = 10'b00_0000_0100,
    ST_LOGFIN   = 10'b00_0000_1000,
    ST_CENTRE   = 10'b00_0001_0000,
    ST_SPREAD   = 10'b00_0010_0000,
    ST_DRAIN1   = 10'b00_0100_0000,
    ST_DRAIN2   = 10'b00_1000_0000,
    ST_RD_ISSUE = 10'b01_0000_0000,
    ST_RD_DONE  = 10'b10_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [BIN_AW-1:0] clr_r, clr_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [3:0]        iter_r, iter_nxt;
  logic [HW-1:0]     h_r, h_nxt;
  logic [DI_W-1:0]   di_r, di_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    step_nxt  = step_r;
    iter_nxt  = iter_r;
    h_nxt     = h_r;
    di_nxt    = di_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BIN_AW'(BINS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        step_nxt = SQ_LO;
        iter_nxt = '0;
        h_nxt    = '0;
        di_nxt   = '0;
        if (start) begin
          if (status.req_read)      state_nxt = ST_RD_ISSUE;
          else if (!status.req_skip) state_nxt = ST_LOG;
        end
      end
      ST_LOG: begin
        if (step_r == SQ_HI) begin
          step_nxt = SQ_LO;
          iter_nxt = iter_r + 1'b1;
          if (iter_r == 4'd15) state_nxt = ST_LOGFIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_LOGFIN: state_nxt = ST_CENTRE;
      ST_CENTRE: begin
        di_nxt    = '0;
        state_nxt = ST_SPREAD;
      end
      ST_SPREAD: begin
        di_nxt = di_r + 1'b1;
        if (di_r == DI_W'(2 * SPREAD)) begin
          if (h_r == HW'(HARMONICS - 1)) begin
            state_nxt = ST_DRAIN1;
          end else begin
            h_nxt     = h_r + 1'b1;
            state_nxt = ST_CENTRE;
          end
        end
      end
      ST_DRAIN1:   state_nxt = ST_DRAIN2;
      ST_DRAIN2:   state_nxt = ST_IDLE;
      ST_RD_ISSUE: state_nxt = ST_RD_DONE;
      ST_RD_DONE:  state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      step_r  <= SQ_LO;
      iter_r  <= '0;
      h_r     <= '0;
      di_r    <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      step_r  <= step_nxt;
      iter_r  <= iter_nxt;
      h_r     <= h_nxt;
      di_r    <= di_nxt;
    end
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_IDLE) && start;
    cmd.sq_en    = (state_r == ST_LOG);
    cmd.sq_step  = step_r;
    cmd.log_fin  = (state_r == ST_LOGFIN);
    cmd.centre   = (state_r == ST_CENTRE);
    cmd.h        = h_r;
    cmd.issue    = (state_r == ST_SPREAD);
    cmd.di       = di_r;
    cmd.rd_issue = (state_r == ST_RD_ISSUE);
    cmd.rd_done  = (state_r == ST_RD_DONE);
    cmd.clr      = (state_r == ST_CLEAR);
    cmd.clr_addr = clr_r;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = (state_r == ST_RD_DONE);

endmodule
`default_nettype wire

// ===== rtl/core/hsa_dpath.sv =====
`default_nettype none
module hsa_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hsa_pkg::cmd_t                     cmd,
  output hsa_pkg::status_t                  status,
  input  logic                              in_action,
  input  logic [hsa_pkg::MAG_W-1:0]         in_magnitude,
  input  logic [hsa_pkg::SPEC_W-1:0]        in_spectral_index,
  input  logic [hsa_pkg::BIN_W-1:0]         in_bin_number,
  input  logic                              cfg_write_en,
  input  logic signed [hsa_pkg::OFS_W-1:0]  cfg_log_offset,
  output logic [hsa_pkg::SAL_W-1:0]         out_salience,
  output logic [hsa_pkg::BIN_W-1:0]         out_bin_echo
);
  import hsa_pkg::*;
  `include "harmonic_salience_accumulator_assert.svh"

  // configuration
  logic signed [OFS_W-1:0] offset_r;
  always_ff @(posedge clk) begin
    if (!rst_n)            offset_r <= OFFSET_RST;
    else if (cfg_write_en) offset_r <= cfg_log_offset;
  end

  assign status.req_read = in_action;
  assign status.req_skip = (in_spectral_index == '0);

  // captured word
  logic [MAG_W-1:0] mag_r;
  logic [BIN_W-1:0] bn_r;
  logic             bn_ok_r;
  logic             bn_ok;
  assign bn_ok = (in_bin_number != '0) && (in_bin_number <= BIN_W'(BINS));

  // leading one and normalised mantissa of the index
  logic [3:0]  e_init;
  logic [30:0] m_init;
  always_comb begin
    e_init = '0;
    for (int i = 0; i < SPEC_W; i++)
      if (in_spectral_index[i]) e_init = 4'(i);
    m_init = 31'(in_spectral_index) << (5'd30 - 5'(e_init));
  end

  // log by squaring: one 16x16 product per cycle, three per square
  logic [30:0] m_r;
  logic [61:0] acc_r;
  logic [15:0] frac_r;
  logic [3:0]  e_r;
  logic [15:0] mul_x, mul_y;
  logic [31:0] prod;
  logic [61:0] total;
  logic [31:0] sq;

  always_comb begin
    mul_x = (cmd.sq_step == SQ_LO) ? m_r[15:0] : {1'b0, m_r[30:16]};
    mul_y = (cmd.sq_step == SQ_HI) ? {1'b0, m_r[30:16]} : m_r[15:0];
    prod  = mul_x * mul_y;
    total = acc_r + (62'(prod) << 32);
    sq    = total[61:30];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r   <= in_magnitude;
      bn_r    <= in_bin_number;
      bn_ok_r <= bn_ok;
      m_r     <= m_init;
      e_r     <= e_init;
      frac_r  <= '0;
    end else if (cmd.sq_en) begin
      case (cmd.sq_step)
        SQ_LO:  acc_r <= 62'(prod);
        SQ_MID: acc_r <= acc_r + (62'(prod) << 17);
        default: begin
          frac_r <= {frac_r[14:0], sq[31]};
          m_r    <= sq[31] ? sq[31:1] : sq[30:0];
        end
      endcase
    end
  end

  // Q.8 log and per-harmonic centre bin
  logic [LG_W-1:0]         lidx_r;
  logic [27:0]             lq;
  logic signed [22:0]      t;
  logic signed [15:0]      centre_r;
  always_comb begin
    lq = 28'({e_r, frac_r}) * 28'd120 + 28'd128;
    t  = 23'($signed({1'b0, lidx_r})) - 23'($signed({1'b0, LGH[cmd.h]}))
         + 23'(offset_r);
  end
  always_ff @(posedge clk) begin
    if (cmd.log_fin) lidx_r   <= lq[26:8];
    if (cmd.centre)  centre_r <= 16'(t >>> 8) + 16'sd1;
  end

  // spread stage 0: bin and weight
  logic signed [15:0] bpos;
  logic [DI_W-1:0]    kk;
  logic               b_ok;
  always_comb begin
    bpos = centre_r + 16'($signed({1'b0, cmd.di})) - 16'(SPREAD);
    kk   = (cmd.di >= DI_W'(SPREAD)) ? cmd.di - DI_W'(SPREAD) : DI_W'(SPREAD) - cmd.di;
    b_ok = (bpos >= 16'sd1) && (bpos <= 16'(BINS));
  end

  logic              v1_r, v2_r;
  logic [BIN_AW-1:0] a1_r, a2_r;
  logic [W_W-1:0]    w1_r;
  logic [16:0]       add2_r;
  logic [31:0]       wprod;
  assign wprod = mag_r * w1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue && b_ok;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r   <= BIN_AW'(bpos - 16'sd1);
    w1_r   <= WTAB[cmd.h][kk[K_W-1:0]];
    a2_r   <= a1_r;
    add2_r <= wprod[31:15];
  end

  // memory ports
  logic [SAL_W-1:0]  mem [BINS];
  logic [SAL_W-1:0]  rdata_r;
  logic [SAL_W:0]    sum_w;
  logic [SAL_W-1:0]  sum;
  logic              rd_en, wr_en;
  logic [BIN_AW-1:0] rd_addr, wr_addr;
  logic [SAL_W-1:0]  wr_data;

  always_comb begin
    sum_w   = {1'b0, rdata_r} + (SAL_W + 1)'(add2_r);
    sum     = sum_w[SAL_W] ? '1 : sum_w[SAL_W-1:0];
    rd_en   = v1_r || cmd.rd_issue;
    rd_addr = v1_r ? a1_r : BIN_AW'(bn_r - 1'b1);
    wr_en   = v2_r || cmd.clr || (cmd.rd_done && bn_ok_r);
    wr_addr = cmd.clr ? cmd.clr_addr : (v2_r ? a2_r : BIN_AW'(bn_r - 1'b1));
    wr_data = v2_r ? sum : '0;
  end

  // read with bypass of the write in flight
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= (v2_r && (a2_r == rd_addr)) ? sum : mem[rd_addr];
  end

  assign out_salience = bn_ok_r ? rdata_r : '0;
  assign out_bin_echo = bn_r;

  `HSA_ASSERT_NOW(a_rd_empty, cmd.rd_issue, !v1_r && !v2_r, "read with spread in flight")
  `HSA_ASSERT_NOW(a_load_empty, cmd.load, !v1_r && !v2_r, "new word with spread in flight")
  `HSA_ASSERT_NOW(a_wr_port, v2_r, !cmd.clr && !cmd.rd_done, "write port clash")
  `HSA_ASSERT_NEXT(a_rd_done, cmd.rd_issue, cmd.rd_done, "read result not delivered")

endmodule
`default_nettype wire

// ===== rtl/core/harmonic_salience_accumulator.sv =====
`default_nettype none
// Harmonic-summation pitch salience map of 480 tenth-semitone bins.
// Input: a word is taken when start is high and busy is low. in_action 0
// adds a spectral peak (in_magnitude, in_spectral_index); 1 reads and
// clears bin in_bin_number. Output: a read gives one word on out_salience
// and out_bin_echo, marked by out_strobe for one cycle in state RD_DONE,
// after RD_ISSUE reads it; the receiver cannot stall. Out-of-range bins
// read as zero. An add holds busy to form the log of the index (16
// squarings, three passes each through one 16x16 multiplier), scale it
// to Q.8, then for each of 8 harmonics set the centre bin and spread
// around it, one read-modify-write per cycle on the salience memory (one
// read, one write port), then drain via DRAIN1 and DRAIN2 and drop busy.
// An index of zero is skipped in idle. cfg_log_offset is written whenever
// cfg_write_en is high; the user must write it only while idle, the block
// does not enforce it. After reset all 480 bins are swept to zero with
// busy high; log_offset resets to -63488.
module harmonic_salience_accumulator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_action,
  input  logic [hsa_pkg::MAG_W-1:0]         in_magnitude,
  input  logic [hsa_pkg::SPEC_W-1:0]        in_spectral_index,
  input  logic [hsa_pkg::BIN_W-1:0]         in_bin_number,
  output logic                              out_strobe,
  output logic [hsa_pkg::SAL_W-1:0]         out_salience,
  output logic [hsa_pkg::BIN_W-1:0]         out_bin_echo,
  input  logic                              cfg_write_en,
  input  logic signed [hsa_pkg::OFS_W-1:0]  cfg_log_offset
);
  import hsa_pkg::*;

  cmd_t    cmd;
  status_t status;

  hsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  hsa_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_action         (in_action),
    .in_magnitude      (in_magnitude),
    .in_spectral_index (in_spectral_index),
    .in_bin_number     (in_bin_number),
    .cfg_write_en      (cfg_write_en),
    .cfg_log_offset    (cfg_log_offset),
    .out_salience      (out_salience),
    .out_bin_echo      (out_bin_echo)
  );

endmodule
`default_nettype wire
